>>> hdl/czb_pkg.sv
package czb_pkg;

  localparam int COORD_BITS_DEF = 19;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int ZONE_COUNT     = 4;

  localparam int RANGE_W   = 18;
  localparam int CNT_W     = 8;
  localparam int GLOB_W    = 10;
  localparam int ZONE_W    = 2;
  localparam int HEIGHT_W  = 19;
  localparam int SQ_W      = 2 * RANGE_W;
  localparam int NUM_W     = RANGE_W + CNT_W;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_TDW   = 1 + ZONE_W + CNT_W + CNT_W + GLOB_W + HEIGHT_W;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_SCALE = 24;
  localparam int ACC_W        = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INNER,
    REG_ZONE2,
    REG_ZONE3,
    REG_ZONE4,
    REG_OUTER,
    REG_RINGS,
    REG_SECTORS
  } cfg_reg_e;

  // per-point bookkeeping that rides alongside the cell chains
  typedef struct packed {
    logic                       oor;
    logic [ZONE_W-1:0]          zone;
    logic [RANGE_W-1:0]         start;
    logic [RANGE_W-1:0]         span;
    logic                       span_ok;
    logic [CNT_W-1:0]           rings;
    logic [CNT_W-1:0]           sectors;
    logic [GLOB_W-1:0]          base;
    logic [HEIGHT_W-1:0]        height;
    logic                       y_zero;
    logic                       x_zero;
    logic                       upper;
    logic                       x_neg;
  } side_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ACC_W-1:0] atan_step(input int i);
    logic [ACC_W-1:0] v;
    unique case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/czb_cordic_cell.sv
module czb_cordic_cell #(
  parameter int DW   = 46,
  parameter int STEP = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [DW-1:0]          cx_i,
  input  logic signed [DW-1:0]          cy_i,
  input  logic [czb_pkg::ACC_W-1:0]     acc_i,
  output logic signed [DW-1:0]          cx_o,
  output logic signed [DW-1:0]          cy_o,
  output logic [czb_pkg::ACC_W-1:0]     acc_o
);

  logic signed [DW-1:0]         cx_d, cy_d, dx, dy;
  logic [czb_pkg::ACC_W-1:0]    acc_d;
  logic                         pos;

  // one vectoring rotation, floor shifts
  always_comb begin
    dx  = cy_i >>> STEP;
    dy  = cx_i >>> STEP;
    pos = !cy_i[DW-1] && (|cy_i);
    if (pos) begin
      cx_d  = cx_i + dx;
      cy_d  = cy_i - dy;
      acc_d = acc_i + czb_pkg::atan_step(STEP);
    end else begin
      cx_d  = cx_i - dx;
      cy_d  = cy_i + dy;
      acc_d = acc_i - czb_pkg::atan_step(STEP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_o  <= cx_d;
      cy_o  <= cy_d;
      acc_o <= acc_d;
    end
  end

endmodule

>>> hdl/czb_sqrt_cell.sv
module czb_sqrt_cell #(
  parameter int QW  = 19,
  parameter int BIT = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [2*QW-1:0]   n_i,
  input  logic [QW+1:0]     rem_i,
  input  logic [QW-1:0]     root_i,
  output logic [2*QW-1:0]   n_o,
  output logic [QW+1:0]     rem_o,
  output logic [QW-1:0]     root_o
);

  logic [QW+1:0] rem_sh, trial, rem_d;
  logic [QW-1:0] root_d;

  // restoring step: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {rem_i[QW-1:0], n_i[2*BIT+1 -: 2]};
    trial  = {root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[QW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o    <= n_i;
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule

>>> hdl/czb_div_cell.sv
module czb_div_cell #(
  parameter int BIT = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          ok_i,
  input  logic [czb_pkg::NUM_W-1:0]     rem_i,
  input  logic [czb_pkg::RANGE_W-1:0]   den_i,
  input  logic [czb_pkg::CNT_W-1:0]     quo_i,
  output logic                          ok_o,
  output logic [czb_pkg::NUM_W-1:0]     rem_o,
  output logic [czb_pkg::RANGE_W-1:0]   den_o,
  output logic [czb_pkg::CNT_W-1:0]     quo_o
);

  logic [czb_pkg::NUM_W-1:0] sub;
  logic [czb_pkg::NUM_W-1:0] rem_d;
  logic [czb_pkg::CNT_W-1:0] quo_d;

  always_comb begin
    sub   = czb_pkg::NUM_W'(den_i) << BIT;
    rem_d = rem_i;
    quo_d = quo_i;
    if (rem_i >= sub) begin
      rem_d      = rem_i - sub;
      quo_d[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_o  <= ok_i;
      rem_o <= rem_d;
      den_o <= den_i;
      quo_o <= quo_d;
    end
  end

endmodule

>>> hdl/concentric_zone_binner.sv
// concentric zone binner: one lidar point in, one bin item out, a new point every
// clock. the depth of the pipe is set by the longer of two cell chains: the 28-cell
// cordic row that finds the azimuth, and the square root row (one cell per root bit)
// followed by an 8-cell divider row that places the radius within its zone. the whole
// pipe moves as one and stalls only when the output item is not taken. range and zone
// tests compare x^2 + y^2 against squared registers, which are refreshed in the cycle
// after a write.
module concentric_zone_binner #(
  parameter int COORD_BITS = czb_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = czb_pkg::ANGLE_BITS_DEF,
  localparam int IN_TDW    = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y, pos_z, zero padded
  input  logic [IN_TDW-1:0]                 s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // in_range, zone_index, ring_index, sector_index, global_ring, height_out
  output logic [czb_pkg::OUT_TDW-1:0]       m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [czb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [czb_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int CW   = COORD_BITS;
  localparam int R2W  = 2 * CW;
  localparam int CMPW = (R2W > czb_pkg::SQ_W) ? R2W : czb_pkg::SQ_W;
  localparam int CDW  = CW + czb_pkg::CORDIC_SCALE + 3;
  localparam int RQX  = (CW > czb_pkg::RANGE_W) ? CW : czb_pkg::RANGE_W;
  localparam int HX   = (CW > czb_pkg::HEIGHT_W) ? CW : czb_pkg::HEIGHT_W;
  localparam int NCOR = czb_pkg::CORDIC_STEPS;
  localparam int NDIV = czb_pkg::CNT_W;
  // stage numbers: 0 input, 1 squares, chains start from stage 1
  localparam int CE   = 1 + NCOR;          // azimuth done
  localparam int SE   = 1 + CW;            // root done
  localparam int MS   = SE + 1;            // numerator product
  localparam int DE   = MS + NDIV;         // quotient done
  localparam int F    = ((CE > DE) ? CE : DE) + 2;

  localparam logic signed [HX-1:0] HMAX = HX'(2 ** (czb_pkg::HEIGHT_W - 1) - 1);
  localparam logic signed [HX-1:0] HMIN = HX'(-(2 ** (czb_pkg::HEIGHT_W - 1)));

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [czb_pkg::RANGE_W-1:0] inner_q, zone2_q, zone3_q, zone4_q, outer_q;
  logic [czb_pkg::CFG_W-1:0]   rings_q, sectors_q;
  logic [czb_pkg::SQ_W-1:0]    inner_sq_q, zone2_sq_q, zone3_sq_q, zone4_sq_q, outer_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q   <= 18'd2700;
      zone2_q   <= 18'd12363;
      zone3_q   <= 18'd22025;
      zone4_q   <= 18'd41350;
      outer_q   <= 18'd80000;
      rings_q   <= 32'd67372034;
      sectors_q <= 32'd540418064;
    end else if (cfg_we_i) begin
      unique case (czb_pkg::cfg_reg_e'(cfg_idx_i))
        czb_pkg::REG_INNER:   inner_q   <= cfg_data_i[czb_pkg::RANGE_W-1:0];
        czb_pkg::REG_ZONE2:   zone2_q   <= cfg_data_i[czb_pkg::RANGE_W-1:0];
        czb_pkg::REG_ZONE3:   zone3_q   <= cfg_data_i[czb_pkg::RANGE_W-1:0];
        czb_pkg::REG_ZONE4:   zone4_q   <= cfg_data_i[czb_pkg::RANGE_W-1:0];
        czb_pkg::REG_OUTER:   outer_q   <= cfg_data_i[czb_pkg::RANGE_W-1:0];
        czb_pkg::REG_RINGS:   rings_q   <= cfg_data_i;
        czb_pkg::REG_SECTORS: sectors_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // squared boundaries, registered from the boundary registers in the cycle after them
  always_ff @(posedge clk_i) begin
    inner_sq_q <= inner_q * inner_q;
    zone2_sq_q <= zone2_q * zone2_q;
    zone3_sq_q <= zone3_q * zone3_q;
    zone4_sq_q <= zone4_q * zone4_q;
    outer_sq_q <= outer_q * outer_q;
  end

  // ---------------------------------------------------------------------------
  // pipe control: every stage moves together
  // ---------------------------------------------------------------------------
  logic [F:0] v_q;
  logic       adv;

  assign adv           = !v_q[F] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v_q[F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[F-1:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: input item
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] x0_q, y0_q, z0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= s_axis_tdata[CW-1:0];
      y0_q <= s_axis_tdata[2*CW-1:CW];
      z0_q <= s_axis_tdata[3*CW-1:2*CW];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: squared range, cordic start (left half plane turned by half a turn)
  // ---------------------------------------------------------------------------
  logic signed [R2W-1:0]      xx, yy;
  logic signed [CDW-1:0]      xs, ys, cx_d, cy_d;
  logic [czb_pkg::ACC_W-1:0]  acc_d;

  logic [R2W-1:0]             r2_q;
  logic signed [CW-1:0]       z1_q;
  logic                       yz1_q, xz1_q, up1_q, xn1_q;
  logic signed [CDW-1:0]      cx1_q, cy1_q;
  logic [czb_pkg::ACC_W-1:0]  acc1_q;

  always_comb begin
    xx = x0_q * x0_q;
    yy = y0_q * y0_q;
    xs = CDW'(x0_q) <<< czb_pkg::CORDIC_SCALE;
    ys = CDW'(y0_q) <<< czb_pkg::CORDIC_SCALE;
    if (x0_q[CW-1]) begin
      cx_d  = -xs;
      cy_d  = -ys;
      acc_d = 32'h8000_0000;
    end else begin
      cx_d  = xs;
      cy_d  = ys;
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_q   <= $unsigned(xx) + $unsigned(yy);
      z1_q   <= z0_q;
      yz1_q  <= (y0_q == '0);
      xz1_q  <= (x0_q == '0);
      up1_q  <= !y0_q[CW-1];
      xn1_q  <= x0_q[CW-1];
      cx1_q  <= cx_d;
      cy1_q  <= cy_d;
      acc1_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: range test, zone choice, per-zone counts
  // ---------------------------------------------------------------------------
  czb_pkg::side_t            side_d;
  czb_pkg::side_t            side_q [2:F-1];
  logic [CMPW-1:0]           r2x;
  logic [czb_pkg::RANGE_W-1:0] nxt;
  logic signed [HX-1:0]      zx;
  logic [czb_pkg::GLOB_W-1:0] rg0, rg1, rg2;

  always_comb begin
    r2x = CMPW'(r2_q);
    rg0 = czb_pkg::GLOB_W'(rings_q[7:0]);
    rg1 = czb_pkg::GLOB_W'(rings_q[15:8]);
    rg2 = czb_pkg::GLOB_W'(rings_q[23:16]);
    side_d.oor = (r2x > CMPW'(outer_sq_q)) || (r2x <= CMPW'(inner_sq_q));
    // first zone whose next boundary lies beyond the point
    priority if (r2x < CMPW'(zone2_sq_q)) side_d.zone = 2'd0;
    else if (r2x < CMPW'(zone3_sq_q))     side_d.zone = 2'd1;
    else if (r2x < CMPW'(zone4_sq_q))     side_d.zone = 2'd2;
    else                                  side_d.zone = 2'd3;
    unique case (side_d.zone)
      2'd0: begin
        side_d.start   = inner_q;
        nxt            = zone2_q;
        side_d.rings   = rings_q[7:0];
        side_d.sectors = sectors_q[7:0];
        side_d.base    = '0;
      end
      2'd1: begin
        side_d.start   = zone2_q;
        nxt            = zone3_q;
        side_d.rings   = rings_q[15:8];
        side_d.sectors = sectors_q[15:8];
        side_d.base    = rg0;
      end
      2'd2: begin
        side_d.start   = zone3_q;
        nxt            = zone4_q;
        side_d.rings   = rings_q[23:16];
        side_d.sectors = sectors_q[23:16];
        side_d.base    = rg0 + rg1;
      end
      default: begin
        side_d.start   = zone4_q;
        nxt            = outer_q;
        side_d.rings   = rings_q[31:24];
        side_d.sectors = sectors_q[31:24];
        side_d.base    = rg0 + rg1 + rg2;
      end
    endcase
    side_d.span    = nxt - side_d.start;
    side_d.span_ok = nxt > side_d.start;
    // height saturates into the output field
    zx = HX'(z1_q);
    if (zx > HMAX)      side_d.height = czb_pkg::HEIGHT_W'(HMAX);
    else if (zx < HMIN) side_d.height = czb_pkg::HEIGHT_W'(HMIN);
    else                side_d.height = czb_pkg::HEIGHT_W'(zx);
    side_d.y_zero = yz1_q;
    side_d.x_zero = xz1_q;
    side_d.upper  = up1_q;
    side_d.x_neg  = xn1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[2] <= side_d;
      for (int k = 3; k < F; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // cordic row: azimuth as a fraction of a turn
  // ---------------------------------------------------------------------------
  logic signed [CDW-1:0]      ccx [0:NCOR];
  logic signed [CDW-1:0]      ccy [0:NCOR];
  logic [czb_pkg::ACC_W-1:0]  cacc [0:NCOR];

  assign ccx[0]  = cx1_q;
  assign ccy[0]  = cy1_q;
  assign cacc[0] = acc1_q;

  for (genvar i = 0; i < NCOR; i++) begin : g_cordic
    czb_cordic_cell #(
      .DW   (CDW),
      .STEP (i)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .cx_i  (ccx[i]),
      .cy_i  (ccy[i]),
      .acc_i (cacc[i]),
      .cx_o  (ccx[i+1]),
      .cy_o  (ccy[i+1]),
      .acc_o (cacc[i+1])
    );
  end

  logic [czb_pkg::ACC_W-1:0] acc_q [CE+1:F-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      acc_q[CE+1] <= cacc[NCOR];
      for (int k = CE + 2; k < F; k++) begin
        acc_q[k] <= acc_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // square root row: one root bit per cell, msb first
  // ---------------------------------------------------------------------------
  logic [R2W-1:0] sn [0:CW];
  logic [CW+1:0]  sr [0:CW];
  logic [CW-1:0]  sroot [0:CW];

  assign sn[0]    = r2_q;
  assign sr[0]    = '0;
  assign sroot[0] = '0;

  for (genvar j = 0; j < CW; j++) begin : g_sqrt
    czb_sqrt_cell #(
      .QW  (CW),
      .BIT (CW - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .n_i    (sn[j]),
      .rem_i  (sr[j]),
      .root_i (sroot[j]),
      .n_o    (sn[j+1]),
      .rem_o  (sr[j+1]),
      .root_o (sroot[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // numerator (r - zone start) * rings
  // ---------------------------------------------------------------------------
  czb_pkg::side_t               sse;
  logic [RQX-1:0]               rq_x, st_x;
  logic [czb_pkg::RANGE_W-1:0]  diff;
  logic [czb_pkg::NUM_W-1:0]    num_q;
  logic [czb_pkg::RANGE_W-1:0]  den_q;
  logic                         ok_q;

  always_comb begin
    sse  = side_q[SE];
    rq_x = RQX'(sroot[CW]);
    st_x = RQX'(sse.start);
    diff = czb_pkg::RANGE_W'(rq_x - st_x);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= diff * sse.rings;
      den_q <= sse.span;
      ok_q  <= sse.span_ok && (rq_x >= st_x);
    end
  end

  // ---------------------------------------------------------------------------
  // divider row: quotient stays below 256 inside a zone
  // ---------------------------------------------------------------------------
  logic                          dok  [0:NDIV];
  logic [czb_pkg::NUM_W-1:0]     drem [0:NDIV];
  logic [czb_pkg::RANGE_W-1:0]   dden [0:NDIV];
  logic [czb_pkg::CNT_W-1:0]     dquo [0:NDIV];

  assign dok[0]  = ok_q;
  assign drem[0] = num_q;
  assign dden[0] = den_q;
  assign dquo[0] = '0;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    czb_div_cell #(
      .BIT (NDIV - 1 - i)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .ok_i  (dok[i]),
      .rem_i (drem[i]),
      .den_i (dden[i]),
      .quo_i (dquo[i]),
      .ok_o  (dok[i+1]),
      .rem_o (drem[i+1]),
      .den_o (dden[i+1]),
      .quo_o (dquo[i+1])
    );
  end

  logic [czb_pkg::CNT_W:0] ring_q [DE+1:F-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ring_q[DE+1] <= {dok[NDIV], dquo[NDIV]};
      for (int k = DE + 2; k < F; k++) begin
        ring_q[k] <= ring_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // final stage: half-plane guard, axis points, sector, clamps, output register
  // ---------------------------------------------------------------------------
  function automatic logic [czb_pkg::CNT_W-1:0] clamp_cnt(
    input logic [czb_pkg::CNT_W-1:0] idx,
    input logic [czb_pkg::CNT_W-1:0] cnt
  );
    logic [czb_pkg::CNT_W-1:0] r;
    if (cnt == '0)                               r = '0;
    else if (idx > cnt - czb_pkg::CNT_W'(1))     r = cnt - czb_pkg::CNT_W'(1);
    else                                         r = idx;
    return r;
  endfunction

  czb_pkg::side_t                   sf;
  logic [czb_pkg::ACC_W-1:0]        acc_f;
  logic [ANGLE_BITS-1:0]            az;
  logic [ANGLE_BITS+czb_pkg::CNT_W-1:0] prod;
  logic [czb_pkg::CNT_W-1:0]        ring_raw, ring_f, sec_f;
  logic [czb_pkg::GLOB_W-1:0]       glob_f;
  logic [czb_pkg::OUT_TDW-1:0]      out_d, out_q;

  always_comb begin
    sf    = side_q[F-1];
    acc_f = acc_q[F-1];
    // keep the angle on the same side of the x axis as the point
    if (sf.upper && acc_f > 32'h8000_0000) begin
      acc_f = (acc_f >= 32'hC000_0000) ? 32'h0 : 32'h8000_0000;
    end else if (!sf.upper && acc_f < 32'h8000_0000) begin
      acc_f = (acc_f < 32'h4000_0000) ? 32'hFFFF_FFFF : 32'h8000_0000;
    end
    // points on an axis
    if (sf.y_zero) begin
      acc_f = sf.x_neg ? 32'h8000_0000 : 32'h0;
    end else if (sf.x_zero) begin
      acc_f = sf.upper ? 32'h4000_0000 : 32'hC000_0000;
    end
    az       = acc_f[czb_pkg::ACC_W-1 -: ANGLE_BITS];
    prod     = az * sf.sectors;
    sec_f    = clamp_cnt(prod[ANGLE_BITS +: czb_pkg::CNT_W], sf.sectors);
    ring_raw = ring_q[F-1][czb_pkg::CNT_W] ? ring_q[F-1][czb_pkg::CNT_W-1:0] : sf.rings;
    ring_f   = clamp_cnt(ring_raw, sf.rings);
    glob_f   = sf.base + czb_pkg::GLOB_W'(ring_f);
    if (sf.oor) begin
      out_d = {sf.height, {(czb_pkg::OUT_TDW - czb_pkg::HEIGHT_W){1'b0}}};
    end else begin
      out_d = {sf.height, glob_f, sec_f, ring_f, sf.zone, 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

endmodule
